// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the RTL; they compile away under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("%m: assertion failed");

`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- hw/rtl/tpsp_pkg.sv -----
package tpsp_pkg;

  // configuration port
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic REG_TOUCH_THRESHOLD = 1'b0;
  localparam logic [9:0] THRESHOLD_RESET = 10'h040;

  // packet framing
  localparam logic [2:0] COUNT_MASK = 3'd7;
  localparam logic [3:0] MIN_PACKET_LEN = 4'd2;
  localparam int unsigned REPORT_DEPTH = 5;
  localparam logic [2:0] FIRST_STORED_POS = 3'd2;

  localparam logic [7:0] FULL_PRESSURE = 8'd255;
  localparam logic [7:0] RELEASE_PRESSURE = 8'd0;

  // axis calibration
  localparam int unsigned X_OFFSET = 32'h0508;
  localparam int unsigned X_SPAN_END = 32'h10c0;
  localparam int unsigned X_MAX = 319;
  localparam int unsigned Y_OFFSET = 32'h0546;
  localparam int unsigned Y_SPAN_END = 32'h1266;
  localparam int unsigned Y_MAX = 239;

  // floor(v * MAX / SPAN) == (v * RECIP) >> RECIP_SHIFT for 0 <= v < SPAN
  localparam int unsigned RECIP_SHIFT = 24;
  localparam int unsigned X_SPAN = X_SPAN_END - X_OFFSET;
  localparam int unsigned Y_SPAN = Y_SPAN_END - Y_OFFSET;
  // MAX << RECIP_SHIFT needs more than 32 bits
  localparam longint unsigned X_RECIP =
    ((longint'(X_MAX) << RECIP_SHIFT) + longint'(X_SPAN) - 1) / longint'(X_SPAN);
  localparam longint unsigned Y_RECIP =
    ((longint'(Y_MAX) << RECIP_SHIFT) + longint'(Y_SPAN) - 1) / longint'(Y_SPAN);

endpackage

// ----- hw/rtl/tpsp_scaler.sv -----
module tpsp_scaler (
  input  logic [15:0] raw_x,
  input  logic [15:0] raw_y,
  output logic [8:0]  x_scaled,
  output logic [7:0]  y_scaled
);

  // offset, scale, mirror and clamp one axis
  function automatic logic [8:0] scale_axis(input logic [15:0] raw,
                                            input logic [16:0] offset,
                                            input logic [11:0] span,
                                            input logic [20:0] recip,
                                            input logic [8:0]  max_val);
    logic [16:0] diff;
    logic [32:0] prod;
    logic [8:0]  quot;
    logic [8:0]  res;
    diff = {1'b0, raw} - offset;
    prod = 33'(diff[11:0]) * 33'(recip);
    quot = prod[32:24];
    if (diff[16] || diff == 17'd0) begin
      res = max_val;
    end else if (diff >= 17'(span)) begin
      res = 9'd0;
    end else begin
      res = max_val - quot;
    end
    return res;
  endfunction

  logic [8:0] y_full;

  assign x_scaled = scale_axis(raw_x, 17'(tpsp_pkg::X_OFFSET), 12'(tpsp_pkg::X_SPAN),
                               21'(tpsp_pkg::X_RECIP), 9'(tpsp_pkg::X_MAX));
  assign y_full   = scale_axis(raw_y, 17'(tpsp_pkg::Y_OFFSET), 12'(tpsp_pkg::Y_SPAN),
                               21'(tpsp_pkg::Y_RECIP), 9'(tpsp_pkg::Y_MAX));
  assign y_scaled = y_full[7:0];

endmodule

// ----- hw/rtl/touch_packet_to_screen_point_core.sv -----
// Touch report decoder: takes controller report bytes and emits screen points.
// Byte channel: packet_byte with byte_valid/byte_ready, one byte per word.
// The low 3 bits of a packet's first byte give n; the packet holds
// max(n,1)+1 bytes. On the final byte the strength byte is compared with
// touch_threshold and a touch (pressure 255) or, if the pen was down, a
// release (pressure 0) at the last point goes out on the point channel
// (x_position, y_position, pressure with point_valid/point_ready).
// Throughput: one byte per cycle unless a stall drops byte_ready, set by the
// single-pass scaler between the decode register and the result register.
// A final byte sets the decode register, then its point the result register.
// A stalled point holds in the result register; one more final word can wait
// in the decode register, after which byte_ready drops until the point moves.
// APB port: touch_threshold at address 0, written at the access cycle.
// Reset: waits for a packet start, pen up, threshold 64, no point pending.
`include "assert_macros.svh"

module touch_packet_to_screen_point_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tpsp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic [7:0]                      packet_byte,
  input  logic                            byte_valid,
  output logic                            byte_ready,
  output logic [8:0]                      x_position,
  output logic [7:0]                      y_position,
  output logic [7:0]                      pressure,
  output logic                            point_valid,
  input  logic                            point_ready
);

  logic [9:0] touch_threshold;
  logic       reg_sel;

  logic [2:0] byte_position;
  logic [3:0] packet_length;
  logic [7:0] report_bytes [tpsp_pkg::REPORT_DEPTH];
  logic [7:0] cur_bytes    [tpsp_pkg::REPORT_DEPTH];

  logic       accept;
  logic       is_start;
  logic       is_final;
  logic [2:0] count;
  logic [3:0] len_next;

  logic        s1_valid;
  logic        s1_touch;
  logic [15:0] s1_raw_x;
  logic [15:0] s1_raw_y;

  logic       stall;
  logic       pen_down;
  logic [8:0] last_x;
  logic [7:0] last_y;
  logic [8:0] x_scaled;
  logic [7:0] y_scaled;

  // configuration port
  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == tpsp_pkg::REG_TOUCH_THRESHOLD);
  assign prdata  = reg_sel ? 32'(touch_threshold) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      touch_threshold <= tpsp_pkg::THRESHOLD_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      touch_threshold <= pwdata[9:0];
    end
  end

  // packet framing
  assign stall      = point_valid && !point_ready;
  assign byte_ready = !s1_valid || !stall;
  assign accept     = byte_valid && byte_ready;
  assign is_start   = (byte_position == 3'd0);
  assign count      = packet_byte[2:0] & tpsp_pkg::COUNT_MASK;
  assign len_next   = (count == 3'd0) ? tpsp_pkg::MIN_PACKET_LEN : {1'b0, count} + 4'd1;
  assign is_final   = !is_start && (({1'b0, byte_position} + 4'd1) >= packet_length);

  // report bytes with the current word overlaid
  always_comb begin
    for (int i = 0; i < tpsp_pkg::REPORT_DEPTH; i++) begin
      if (byte_position == tpsp_pkg::FIRST_STORED_POS + 3'(i)) begin
        cur_bytes[i] = packet_byte;
      end else begin
        cur_bytes[i] = report_bytes[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= 3'd0;
      packet_length <= 4'd0;
    end else if (accept) begin
      if (is_start) begin
        packet_length <= len_next;
        byte_position <= 3'd1;
      end else if (is_final) begin
        byte_position <= 3'd0;
      end else begin
        byte_position <= byte_position + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < tpsp_pkg::REPORT_DEPTH; i++) begin
        report_bytes[i] <= is_start ? 8'd0 : cur_bytes[i];
      end
    end
  end

  // decode register: one finished packet waiting for the scaler
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_ready) begin
      s1_valid <= accept && is_final;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_ready) begin
      s1_touch <= {2'b00, cur_bytes[4]} > touch_threshold;
      s1_raw_x <= {cur_bytes[2], cur_bytes[3]};
      s1_raw_y <= {cur_bytes[0], cur_bytes[1]};
    end
  end

  tpsp_scaler u_scaler (
    .raw_x    (s1_raw_x),
    .raw_y    (s1_raw_y),
    .x_scaled (x_scaled),
    .y_scaled (y_scaled)
  );

  // result register and pen tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      point_valid <= 1'b0;
      pen_down    <= 1'b0;
    end else if (!stall) begin
      point_valid <= 1'b0;
      if (s1_valid) begin
        if (s1_touch) begin
          point_valid <= 1'b1;
          pen_down    <= 1'b1;
        end else if (pen_down) begin
          point_valid <= 1'b1;
          pen_down    <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!stall && s1_valid) begin
      if (s1_touch) begin
        last_x     <= x_scaled;
        last_y     <= y_scaled;
        x_position <= x_scaled;
        y_position <= y_scaled;
        pressure   <= tpsp_pkg::FULL_PRESSURE;
      end else begin
        x_position <= last_x;
        y_position <= last_y;
        pressure   <= tpsp_pkg::RELEASE_PRESSURE;
      end
    end
  end

  `ASSERT_IMPLIES(a_point_in_screen, clk, rst, point_valid, (x_position <= 9'(tpsp_pkg::X_MAX)) && (y_position <= 8'(tpsp_pkg::Y_MAX)))
  `ASSERT_IMPLIES(a_ready_only_on_stall, clk, rst, !byte_ready, s1_valid && point_valid && !point_ready)
  `ASSERT_NEXT(a_release_drops_pen, clk, rst, s1_valid && !stall && !s1_touch && pen_down, point_valid && (pressure == tpsp_pkg::RELEASE_PRESSURE) && !pen_down)
  `ASSERT_IMPLIES(a_position_in_packet, clk, rst, byte_position != 3'd0, {1'b0, byte_position} < packet_length)

endmodule

// ----- sim/tb.sv -----
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpsp_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [8:0] x;
    logic [7:0] y;
    logic [7:0] p;
  } point_t;

  class point_scoreboard;
    logic [9:0] threshold;
    logic [2:0] next_pos;
    logic [3:0] pkt_len;
    logic [7:0] report [REPORT_DEPTH];
    bit         pen_down;
    logic [8:0] last_x;
    logic [7:0] last_y;
    point_t     expected_points[$];
    int         fails;

    function new();
      threshold = THRESHOLD_RESET;
      next_pos = '0;
      pkt_len = '0;
      pen_down = 1'b0;
      last_x = '0;
      last_y = '0;
      fails = 0;
      foreach (report[i]) report[i] = '0;
    endfunction

    function void set_threshold(logic [31:0] value);
      threshold = value[9:0];
    endfunction

    function int scale_axis(int raw, int offset, int span_end, int max_val);
      int v;
      v = ((raw - offset) * max_val) / (span_end - offset);
      v = max_val - v;
      if (v < 0) v = 0;
      if (v > max_val) v = max_val;
      return v;
    endfunction

    function void note_byte(logic [7:0] data);
      int n;
      int rx;
      int ry;
      if (next_pos == 3'd0) begin
        n = int'(data[2:0] & COUNT_MASK);
        if (n < 1) n = 1;
        pkt_len = 4'(n + 1);
        foreach (report[i]) report[i] = '0;
        next_pos = 3'd1;
        return;
      end
      if (next_pos >= FIRST_STORED_POS && next_pos <= 3'd6)
        report[next_pos - FIRST_STORED_POS] = data;
      if (int'(next_pos) + 1 < int'(pkt_len)) begin
        next_pos = next_pos + 3'd1;
        return;
      end
      next_pos = 3'd0;
      if (10'(report[4]) > threshold) begin
        rx = {report[2], report[3]};
        ry = {report[0], report[1]};
        last_x = 9'(scale_axis(rx, X_OFFSET, X_SPAN_END, X_MAX));
        last_y = 8'(scale_axis(ry, Y_OFFSET, Y_SPAN_END, Y_MAX));
        pen_down = 1'b1;
        expected_points.push_back('{last_x, last_y, FULL_PRESSURE});
      end else if (pen_down) begin
        pen_down = 1'b0;
        expected_points.push_back('{last_x, last_y, RELEASE_PRESSURE});
      end
    endfunction

    function void check_point(logic [8:0] x, logic [7:0] y, logic [7:0] p);
      point_t want;
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected point x=%0d y=%0d pressure=%0d", $time, x, y, p);
        fails++;
        return;
      end
      want = expected_points.pop_front();
      if (x !== want.x) begin
        $display("%0t: x_position expected %0d actual %0d", $time, want.x, x);
        fails++;
      end
      if (y !== want.y) begin
        $display("%0t: y_position expected %0d actual %0d", $time, want.y, y);
        fails++;
      end
      if (p !== want.p) begin
        $display("%0t: pressure expected %0d actual %0d", $time, want.p, p);
        fails++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;
  logic [7:0]            packet_byte;
  logic                  byte_valid;
  logic                  byte_ready;
  logic [8:0]            x_position;
  logic [7:0]            y_position;
  logic [7:0]            pressure;
  logic                  point_valid;
  logic                  point_ready;

  point_scoreboard sb;
  bit              steady;
  int              cur_threshold;
  int              cycles;

  touch_packet_to_screen_point_core dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .packet_byte (packet_byte),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .x_position  (x_position),
    .y_position  (y_position),
    .pressure    (pressure),
    .point_valid (point_valid),
    .point_ready (point_ready)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // check before noting: a point never belongs to the word accepted at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (point_valid && point_ready) sb.check_point(x_position, y_position, pressure);
      if (byte_valid && byte_ready) sb.note_byte(packet_byte);
    end
  end

  always @(negedge clk) begin
    point_ready <= steady || ($urandom_range(99) >= 25);
  end

  task automatic send_word(input logic [7:0] data);
    while (!steady && $urandom_range(99) < 25) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    packet_byte <= data;
    do @(posedge clk); while (!byte_ready);
    @(negedge clk);
  endtask

  task automatic send_packet(input logic [7:0] first, input logic [15:0] rx,
                             input logic [15:0] ry, input logic [7:0] strength);
    logic [7:0] words [8];
    int len;
    words = '{first, 8'($urandom), ry[15:8], ry[7:0], rx[15:8], rx[7:0], strength,
              8'($urandom)};
    len = ((first & COUNT_MASK) == 8'd0) ? 2 : int'(first[2:0]) + 1;
    for (int i = 0; i < len; i++) send_word(words[i]);
  endtask

  function automatic logic [15:0] rand_raw(input int lo, input int hi);
    // mostly inside the calibrated span, a little past both ends
    if ($urandom_range(99) < 70) return 16'($urandom_range(hi + 8, lo - 8));
    return 16'($urandom);
  endfunction

  task automatic run_random(input int count);
    int sent;
    int roll;
    logic [2:0] n;
    logic [7:0] strength;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(99);
      n = (roll < 70) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(7));
      roll = $urandom_range(99);
      if (roll < 45 && cur_threshold < 255)
        strength = 8'($urandom_range(255, cur_threshold + 1));
      else if (roll < 55 && cur_threshold <= 255)
        strength = 8'(cur_threshold);
      else
        strength = 8'($urandom);
      send_packet({5'($urandom), n}, rand_raw(X_OFFSET, X_SPAN_END),
                  rand_raw(Y_OFFSET, Y_SPAN_END), strength);
      sent += (n == 3'd0) ? 2 : int'(n) + 1;
    end
  endtask

  task automatic wait_drained();
    byte_valid <= 1'b0;
    while (sb.expected_points.size() != 0) @(negedge clk);
    // a final word with no point may still be in flight
    repeat (4) @(negedge clk);
  endtask

  task automatic write_threshold(input logic [9:0] value);
    logic [31:0] data;
    data = $urandom;
    data[9:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(4 * REG_TOUCH_THRESHOLD);
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_threshold(data);
    cur_threshold = value;
    @(negedge clk);
    // read back in a following transfer
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[9:0] !== value) begin
      $display("%0t: touch_threshold expected %0d actual %0d", $time, value, prdata[9:0]);
      sb.fails++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    sb = new();
    cycles = 0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    packet_byte = '0;
    byte_valid = 1'b0;
    point_ready = 1'b0;
    steady = 1'b0;
    cur_threshold = THRESHOLD_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // full packet, raw below span: touch clamps to the far corner
    send_packet(8'hFF, 16'h0000, 16'h0000, 8'(THRESHOLD_RESET + 1));
    // two-word packet: strength reads zero, release at last point
    send_packet(8'h00, 16'h0000, 16'h0000, 8'h00);
    // pen up, no touch: nothing comes out
    send_packet(8'h01, 16'hFFFF, 16'hFFFF, 8'hFF);
    // raw above span: touch clamps to zero
    send_packet(8'hFE, 16'hFFFF, 16'hFFFF, 8'hFF);
    wait_drained();

    write_threshold(10'd0);
    // exact span ends, weakest touch that passes
    send_packet(8'h07, 16'(X_OFFSET), 16'(Y_SPAN_END), 8'd1);
    steady = 1'b1;
    run_random(150);
    steady = 1'b0;
    wait_drained();

    write_threshold(10'd1023);
    run_random(100);
    wait_drained();

    write_threshold(10'($urandom_range(1023)));
    run_random(150);
    // hold the sender until every point is out
    wait_drained();
    run_random(200);
    wait_drained();

    write_threshold(10'($urandom_range(255)));
    run_random(200);
    wait_drained();

    repeat (10) @(negedge clk);
    if (sb.fails == 0 && sb.expected_points.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
